// ===== rtl/core/pdb_pkg.sv =====
// ----------------------------------------------------------------------------
// Porter-Duff blend filter package
// Shared types, register indexes, blend modes and the operand selection
// function that maps a blend mode onto the common per-channel datapath.
// ----------------------------------------------------------------------------
package pdb_pkg;

  localparam int ChanW     = 8;
  localparam int NumChan   = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;
  localparam int PipeDepth = 5;
  localparam int RoundBias = 128;
  localparam int DivShift  = 8;
  localparam int ChanMax   = 255;

  // Channel order inside the datapath arrays.
  localparam int CH_ALPHA = 0;
  localparam int CH_RED   = 1;
  localparam int CH_GREEN = 2;
  localparam int CH_BLUE  = 3;

  typedef logic [ChanW-1:0]    chan_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t REG_BLEND_MODE = 3'd0;
  localparam cfg_idx_t REG_SRC_ALPHA  = 3'd1;
  localparam cfg_idx_t REG_SRC_RED    = 3'd2;
  localparam cfg_idx_t REG_SRC_GREEN  = 3'd3;
  localparam cfg_idx_t REG_SRC_BLUE   = 3'd4;

  typedef enum logic [3:0] {
    MODE_CLEAR   = 4'd0,
    MODE_SRC     = 4'd1,
    MODE_DST     = 4'd2,
    MODE_SRCOVER = 4'd3,
    MODE_DSTOVER = 4'd4,
    MODE_SRCIN   = 4'd5,
    MODE_DSTIN   = 4'd6,
    MODE_SRCOUT  = 4'd7,
    MODE_DSTOUT  = 4'd8,
    MODE_SRCATOP = 4'd9,
    MODE_DSTATOP = 4'd10,
    MODE_XOR     = 4'd11
  } mode_t;

  // Every mode is written as base +/- d(a1*b1 + a2*b2).
  typedef struct packed {
    chan_t      a1;
    chan_t      b1;
    chan_t      a2;
    chan_t      b2;
    logic [8:0] base;
    logic       sub;
  } blend_ops_t;

  function automatic blend_ops_t blend_select(mode_t mode, chan_t s, chan_t d,
                                              chan_t sa, chan_t da, logic is_alpha);
    blend_ops_t ops;
    ops = '0;
    // For 8-bit operands, 255 - x is the bitwise complement.
    unique case (mode)
      MODE_SRC: begin
        ops.base = {1'b0, s};
      end
      MODE_DST: begin
        ops.base = {1'b0, d};
      end
      MODE_SRCOVER: begin
        ops.base = {1'b0, s};
        ops.a1   = ~sa;
        ops.b1   = d;
      end
      MODE_DSTOVER: begin
        ops.base = {1'b0, d};
        ops.a1   = ~da;
        ops.b1   = s;
      end
      MODE_SRCIN: begin
        ops.a1 = s;
        ops.b1 = da;
      end
      MODE_DSTIN: begin
        ops.a1 = d;
        ops.b1 = sa;
      end
      MODE_SRCOUT: begin
        ops.a1 = s;
        ops.b1 = ~da;
      end
      MODE_DSTOUT: begin
        ops.a1 = d;
        ops.b1 = ~sa;
      end
      MODE_SRCATOP: begin
        if (is_alpha) begin
          ops.base = {1'b0, da};
        end else begin
          ops.a1 = s;
          ops.b1 = da;
          ops.a2 = d;
          ops.b2 = ~sa;
        end
      end
      MODE_DSTATOP: begin
        if (is_alpha) begin
          ops.base = {1'b0, sa};
        end else begin
          ops.a1 = d;
          ops.b1 = sa;
          ops.a2 = s;
          ops.b2 = ~da;
        end
      end
      MODE_XOR: begin
        if (is_alpha) begin
          // Sa + Da - d(2*Sa*Da): the doubled product uses both multipliers.
          ops.base = {1'b0, sa} + {1'b0, da};
          ops.sub  = 1'b1;
          ops.a1   = sa;
          ops.b1   = da;
          ops.a2   = sa;
          ops.b2   = da;
        end else begin
          ops.a1 = s;
          ops.b1 = ~da;
          ops.a2 = d;
          ops.b2 = ~sa;
        end
      end
      default: begin
        ops = '0;
      end
    endcase
    return ops;
  endfunction

endpackage

// ===== rtl/core/pdb_in_if.sv =====
// ----------------------------------------------------------------------------
// Porter-Duff blend filter input channel
// Destination pixel stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdb_in_if;
  logic           valid;
  logic           ready;
  pdb_pkg::chan_t dst_alpha;
  pdb_pkg::chan_t dst_red;
  pdb_pkg::chan_t dst_green;
  pdb_pkg::chan_t dst_blue;
  logic           last_in;

  modport source (
    output valid, dst_alpha, dst_red, dst_green, dst_blue, last_in,
    input  ready
  );

  modport sink (
    input  valid, dst_alpha, dst_red, dst_green, dst_blue, last_in,
    output ready
  );
endinterface

// ===== rtl/core/pdb_out_if.sv =====
// ----------------------------------------------------------------------------
// Porter-Duff blend filter result channel
// Blended pixel stream with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdb_out_if;
  logic           valid;
  logic           ready;
  pdb_pkg::chan_t res_alpha;
  pdb_pkg::chan_t res_red;
  pdb_pkg::chan_t res_green;
  pdb_pkg::chan_t res_blue;
  logic           last_out;

  modport source (
    output valid, res_alpha, res_red, res_green, res_blue, last_out,
    input  ready
  );

  modport sink (
    input  valid, res_alpha, res_red, res_green, res_blue, last_out,
    output ready
  );
endinterface

// ===== rtl/core/porter_duff_blend_filter_core.sv =====
// ----------------------------------------------------------------------------
// Porter-Duff blend filter core
// Blends each premultiplied ARGB8888 destination pixel with a constant
// premultiplied source color in one of twelve Porter-Duff modes.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Payload
// in_if     in   valid/ready   dst_alpha, dst_red, dst_green, dst_blue, last_in
// out_if    out  valid/ready   res_alpha, res_red, res_green, res_blue, last_out
// cfg_*     in   cfg_we        cfg_index, cfg_wdata
//
// One pixel per cycle sustained while out_if.ready holds; each accepted pixel
// passes through the five register stages: operand select, multiply,
// rounding bias, divide by 255, and combine with saturation.
// Reset clears all stage valid bits and loads the register defaults.
// A stage holds while its successor is full and stalled; empty stages fill
// behind it, so bubbles are squeezed out and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module porter_duff_blend_filter_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  pdb_pkg::cfg_idx_t   cfg_index,
  input  pdb_pkg::cfg_data_t  cfg_wdata,
  pdb_in_if.sink              in_if,
  pdb_out_if.source           out_if
);
  import pdb_pkg::*;

  typedef struct packed {
    logic [15:0] p1;
    logic [15:0] p2;
    logic [8:0]  base;
    logic        sub;
  } prod_stage_t;

  typedef struct packed {
    logic [17:0] y;
    logic [8:0]  base;
    logic        sub;
  } bias_stage_t;

  typedef struct packed {
    logic [9:0]  q;
    logic [8:0]  base;
    logic        sub;
  } quot_stage_t;

  // Configuration registers.
  logic [3:0]  mode_r;
  chan_t       src_r [NumChan];

  // Pipeline control.
  logic [PipeDepth-1:0] v_r;
  logic [PipeDepth-1:0] v_nxt;
  logic [PipeDepth-1:0] adv;
  logic [PipeDepth-1:0] last_r;
  logic                 in_acc;
  logic                 out_acc;

  // Datapath.
  chan_t       dst      [NumChan];
  blend_ops_t  ops_nxt  [NumChan];
  blend_ops_t  ops_r    [NumChan];
  prod_stage_t prod_nxt [NumChan];
  prod_stage_t prod_r   [NumChan];
  bias_stage_t bias_nxt [NumChan];
  bias_stage_t bias_r   [NumChan];
  quot_stage_t quot_nxt [NumChan];
  quot_stage_t quot_r   [NumChan];
  chan_t       res_nxt  [NumChan];
  chan_t       res_r    [NumChan];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SRCOVER;
      for (int c = 0; c < NumChan; c++) begin
        src_r[c] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLEND_MODE: mode_r          <= cfg_wdata[3:0];
        REG_SRC_ALPHA:  src_r[CH_ALPHA] <= cfg_wdata;
        REG_SRC_RED:    src_r[CH_RED]   <= cfg_wdata;
        REG_SRC_GREEN:  src_r[CH_GREEN] <= cfg_wdata;
        REG_SRC_BLUE:   src_r[CH_BLUE]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    adv[PipeDepth-1] = !v_r[PipeDepth-1] || out_if.ready;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
    v_nxt[0] = adv[0] ? in_if.valid : v_r[0];
    for (int k = 1; k < PipeDepth; k++) begin
      v_nxt[k] = adv[k] ? v_r[k-1] : v_r[k];
    end
  end

  assign in_if.ready = adv[0];
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_acc     = out_if.valid && out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign dst[CH_ALPHA] = in_if.dst_alpha;
  assign dst[CH_RED]   = in_if.dst_red;
  assign dst[CH_GREEN] = in_if.dst_green;
  assign dst[CH_BLUE]  = in_if.dst_blue;

  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      ops_nxt[c] = blend_select(mode_t'(mode_r), src_r[c], dst[c], src_r[CH_ALPHA],
                                in_if.dst_alpha, logic'(c == CH_ALPHA));

      prod_nxt[c].p1   = 16'(ops_r[c].a1) * 16'(ops_r[c].b1);
      prod_nxt[c].p2   = 16'(ops_r[c].a2) * 16'(ops_r[c].b2);
      prod_nxt[c].base = ops_r[c].base;
      prod_nxt[c].sub  = ops_r[c].sub;

      bias_nxt[c].y    = 18'(prod_r[c].p1) + 18'(prod_r[c].p2) + 18'(RoundBias);
      bias_nxt[c].base = prod_r[c].base;
      bias_nxt[c].sub  = prod_r[c].sub;

      // d(x) = (y + (y >> 8)) >> 8 with y = x + 128; the quotient stays below 511.
      quot_nxt[c].q    = 10'((bias_r[c].y + (bias_r[c].y >> DivShift)) >> DivShift);
      quot_nxt[c].base = bias_r[c].base;
      quot_nxt[c].sub  = bias_r[c].sub;
    end
  end

  always_comb begin
    logic signed [10:0] sum;
    for (int c = 0; c < NumChan; c++) begin
      if (quot_r[c].sub) begin
        sum = $signed({2'b00, quot_r[c].base}) - $signed({1'b0, quot_r[c].q});
      end else begin
        sum = $signed({2'b00, quot_r[c].base}) + $signed({1'b0, quot_r[c].q});
      end
      if (sum < 11'sd0) begin
        res_nxt[c] = '0;
      end else if (sum > 11'(ChanMax)) begin
        res_nxt[c] = chan_t'(ChanMax);
      end else begin
        res_nxt[c] = sum[ChanW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      last_r[0] <= in_if.last_in;
      ops_r     <= ops_nxt;
    end
    if (adv[1]) begin
      last_r[1] <= last_r[0];
      prod_r    <= prod_nxt;
    end
    if (adv[2]) begin
      last_r[2] <= last_r[1];
      bias_r    <= bias_nxt;
    end
    if (adv[3]) begin
      last_r[3] <= last_r[2];
      quot_r    <= quot_nxt;
    end
    if (adv[4]) begin
      last_r[4] <= last_r[3];
      res_r     <= res_nxt;
    end
  end

  assign out_if.valid     = v_r[PipeDepth-1];
  assign out_if.res_alpha = res_r[CH_ALPHA];
  assign out_if.res_red   = res_r[CH_RED];
  assign out_if.res_green = res_r[CH_GREEN];
  assign out_if.res_blue  = res_r[CH_BLUE];
  assign out_if.last_out  = last_r[PipeDepth-1];

  // A full pipeline facing a stalled sink takes no new transaction.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&v_r) && !out_if.ready) |-> !in_if.ready)
    else $error("input accepted while the pipeline is full and stalled");

  // Occupancy moves exactly by what enters and what leaves.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> ($countones(v_r) ==
               $countones($past(v_r)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pipeline occupancy does not match accepted transactions");

  // A transaction taken into an empty pipeline lands in the first stage.
  a_first_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (!(|v_r) && in_if.valid) |=> v_r[0])
    else $error("accepted transaction missing from the first stage");

endmodule
